@@ sv/ssb_pkg.sv @@
// Shared constants and types for the scaled sprite blitter.
// Field widths, action and register codes, color key and the register bank type.
// No dependencies.
package ssb_pkg;

  // Field widths of the item and result ports
  localparam int ACTION_W     = 2;
  localparam int LOAD_POS_W   = 6;
  localparam int COLOR_W      = 32;
  localparam int SRC_SIZE_W   = 7;
  localparam int DEST_W       = 12;
  localparam int COUNT_W      = 11;
  localparam int SCREEN_POS_W = 13;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEST_LEFT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEST_TOP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd5;

  // Transparent color and destination size limit
  localparam logic [COLOR_W-1:0] TRANSPARENT_KEY = 32'hFFFF_FFFF;
  localparam logic [DEST_W-1:0]  DEST_MAX        = 12'd2048;

  // Register bank
  typedef struct packed {
    logic [SRC_SIZE_W-1:0] src_width;
    logic [SRC_SIZE_W-1:0] src_height;
    logic [DEST_W-1:0]     dest_left;
    logic [DEST_W-1:0]     dest_top;
    logic [DEST_W-1:0]     dest_width;
    logic [DEST_W-1:0]     dest_height;
  } cfg_regs_t;

endpackage

@@ sv/scaled_sprite_blitter_top.sv @@
// Scaled sprite blitter: sprite store, shared step divider and raster walker.
// Uses ssb_pkg for widths, codes and the register bank type.
// Single module; the sprite store is an inferred RAM inside it.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   action, load_col, load_row, load_color
//   out      source     out_valid_o / out_stall_i pixel_valid .. last_pixel
//   cfg      APB slave  psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// A step result sits in the output register in the cycle after the step item is taken,
// and steps are taken every cycle while that register drains.
// A start item runs the shared restoring divider for both axes, one quotient bit per
// cycle, with in_stall_o high throughout.
// Reset is asynchronous, active low; the sprite store is not cleared and holds garbage
// until loaded. in_stall_o also rises while a result is held by out_stall_i.
module scaled_sprite_blitter_top
  import ssb_pkg::*;
#(
  parameter int MAX_SPRITE_DIM = 64,
  parameter int SCREEN_W       = 1024,
  parameter int SCREEN_H       = 768,
  parameter int FRAC_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PADDR_W-1:0]             paddr,
  input  logic [PDATA_W-1:0]             pwdata,
  output logic [PDATA_W-1:0]             prdata,
  output logic                           pready,
  // item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ACTION_W-1:0]            action_i,
  input  logic [LOAD_POS_W-1:0]          load_col_i,
  input  logic [LOAD_POS_W-1:0]          load_row_i,
  input  logic [COLOR_W-1:0]             load_color_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pixel_valid_o,
  output logic                           write_enable_o,
  output logic signed [SCREEN_POS_W-1:0] screen_col_o,
  output logic signed [SCREEN_POS_W-1:0] screen_row_o,
  output logic [COLOR_W-1:0]             color_o,
  output logic                           last_pixel_o
);

  // Derived sizes
  localparam int DIM_W     = $clog2(MAX_SPRITE_DIM);
  localparam int MEM_DEPTH = 1 << (2 * DIM_W);
  localparam int ACC_W     = DIM_W + FRAC_BITS;
  localparam int DIV_N     = SRC_SIZE_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_N);
  localparam int CMP_W     = (DIV_N > ACC_W + 1) ? DIV_N : ACC_W + 1;
  localparam int SZ_CMP_W  = (DIM_W + 1 > SRC_SIZE_W) ? DIM_W + 1 : SRC_SIZE_W;
  localparam int LM_W      = (DIM_W + 1 > LOAD_POS_W) ? DIM_W + 1 : LOAD_POS_W;
  localparam int MOD_STEPS = ((1 << LOAD_POS_W) - 1) / MAX_SPRITE_DIM;
  localparam int SCR_CMP_W = SCREEN_POS_W + 1;

  localparam logic [ACC_W:0]   ACC_LIM = (ACC_W + 1)'(MAX_SPRITE_DIM) << FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(ACC_LIM - 1'b1);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV_X = 2'd1;
  localparam logic [1:0] ST_DIV_Y = 2'd2;

  cfg_regs_t cfg_q;

  logic [1:0]         state_q;
  logic [DIV_N-1:0]   div_num_q;
  logic [COUNT_W-1:0] div_rem_q;
  logic [CNT_W-1:0]   div_cnt_q;

  logic [ACC_W-1:0]   step_x_q, step_y_q, acc_x_q, acc_y_q;
  logic [COUNT_W-1:0] col_cnt_q, row_cnt_q;
  logic               active_q;

  logic                    ov_q, pv_q, onscr_q, last_q;
  logic [SCREEN_POS_W-1:0] col_q, row_q;
  logic [COLOR_W-1:0]      rd_q;

  logic [COLOR_W-1:0] sprite_mem [MEM_DEPTH];

  // ---------------------------------------------------------------------------
  // Configuration port
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_WIDTH:   prdata = PDATA_W'(cfg_q.src_width);
      REG_SRC_HEIGHT:  prdata = PDATA_W'(cfg_q.src_height);
      REG_DEST_LEFT:   prdata = PDATA_W'(cfg_q.dest_left);
      REG_DEST_TOP:    prdata = PDATA_W'(cfg_q.dest_top);
      REG_DEST_WIDTH:  prdata = PDATA_W'(cfg_q.dest_width);
      REG_DEST_HEIGHT: prdata = PDATA_W'(cfg_q.dest_height);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width   <= 7'd64;
      cfg_q.src_height  <= 7'd64;
      cfg_q.dest_left   <= '0;
      cfg_q.dest_top    <= '0;
      cfg_q.dest_width  <= 12'd64;
      cfg_q.dest_height <= 12'd64;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:   cfg_q.src_width   <= pwdata[SRC_SIZE_W-1:0];
        REG_SRC_HEIGHT:  cfg_q.src_height  <= pwdata[SRC_SIZE_W-1:0];
        REG_DEST_LEFT:   cfg_q.dest_left   <= pwdata[DEST_W-1:0];
        REG_DEST_TOP:    cfg_q.dest_top    <= pwdata[DEST_W-1:0];
        REG_DEST_WIDTH:  cfg_q.dest_width  <= pwdata[DEST_W-1:0];
        REG_DEST_HEIGHT: cfg_q.dest_height <= pwdata[DEST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clamped sizes
  logic [SRC_SIZE_W-1:0] sw_c, sh_c;
  logic [DEST_W-1:0]     dw_c, dh_c;

  always_comb begin
    if (cfg_q.src_width == '0) sw_c = SRC_SIZE_W'(1);
    else if (SZ_CMP_W'(cfg_q.src_width) > SZ_CMP_W'(MAX_SPRITE_DIM))
      sw_c = SRC_SIZE_W'(MAX_SPRITE_DIM);
    else sw_c = cfg_q.src_width;

    if (cfg_q.src_height == '0) sh_c = SRC_SIZE_W'(1);
    else if (SZ_CMP_W'(cfg_q.src_height) > SZ_CMP_W'(MAX_SPRITE_DIM))
      sh_c = SRC_SIZE_W'(MAX_SPRITE_DIM);
    else sh_c = cfg_q.src_height;

    if (cfg_q.dest_width == '0) dw_c = DEST_W'(1);
    else if (cfg_q.dest_width > DEST_MAX) dw_c = DEST_MAX;
    else dw_c = cfg_q.dest_width;

    if (cfg_q.dest_height == '0) dh_c = DEST_W'(1);
    else if (cfg_q.dest_height > DEST_MAX) dh_c = DEST_MAX;
    else dh_c = cfg_q.dest_height;
  end

  // ---------------------------------------------------------------------------
  // Item handshake
  logic in_acc, is_load, is_start, is_step;

  assign in_stall_o = (state_q != ST_IDLE) | (ov_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_load    = in_acc & (action_i == ACT_LOAD);
  assign is_start   = in_acc & (action_i == ACT_START);
  assign is_step    = in_acc & (action_i == ACT_STEP);

  // ---------------------------------------------------------------------------
  // Shared divider: one restoring step per cycle, divisor picked by phase
  logic [DEST_W-1:0]  div_dst;
  logic [DEST_W-1:0]  div_shift;
  logic [DEST_W:0]    div_diff;
  logic               div_ge;
  logic [COUNT_W-1:0] div_rem_d;
  logic [DIV_N-1:0]   div_quot;
  logic [ACC_W-1:0]   div_sat;

  always_comb begin
    div_dst   = (state_q == ST_DIV_Y) ? dh_c : dw_c;
    div_shift = {div_rem_q, div_num_q[DIV_N-1]};
    div_diff  = {1'b0, div_shift} - {1'b0, div_dst};
    div_ge    = ~div_diff[DEST_W];
    div_rem_d = div_ge ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
    div_quot  = {div_num_q[DIV_N-2:0], div_ge};
    if (CMP_W'(div_quot) > CMP_W'(ACC_MAX)) div_sat = ACC_MAX;
    else div_sat = ACC_W'(div_quot);
  end

  // ---------------------------------------------------------------------------
  // Raster walk: end tests, shared saturating accumulator adder
  logic             end_col, end_row;
  logic [ACC_W-1:0] add_a, add_b, add_sat;
  logic [ACC_W:0]   add_sum;

  always_comb begin
    end_col = {1'b0, col_cnt_q} >= (dw_c - 1'b1);
    end_row = {1'b0, row_cnt_q} >= (dh_c - 1'b1);
    add_a   = end_col ? acc_y_q  : acc_x_q;
    add_b   = end_col ? step_y_q : step_x_q;
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    if (add_sum > {1'b0, ACC_MAX}) add_sat = ACC_MAX;
    else add_sat = add_sum[ACC_W-1:0];
  end

  // Sequencer, step registers and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_num_q <= '0;
      div_rem_q <= '0;
      div_cnt_q <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      active_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (is_start) begin
            state_q   <= ST_DIV_X;
            div_num_q <= DIV_N'(sw_c) << FRAC_BITS;
            div_rem_q <= '0;
            div_cnt_q <= CNT_W'(DIV_N - 1);
            acc_x_q   <= '0;
            acc_y_q   <= '0;
            col_cnt_q <= '0;
            row_cnt_q <= '0;
            active_q  <= 1'b1;
          end else if (is_step && active_q) begin
            if (end_col) begin
              col_cnt_q <= '0;
              acc_x_q   <= '0;
              if (end_row) begin
                active_q  <= 1'b0;
                row_cnt_q <= '0;
                acc_y_q   <= '0;
              end else begin
                row_cnt_q <= row_cnt_q + 1'b1;
                acc_y_q   <= add_sat;
              end
            end else begin
              col_cnt_q <= col_cnt_q + 1'b1;
              acc_x_q   <= add_sat;
            end
          end
        end
        ST_DIV_X: begin
          div_num_q <= div_quot;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            step_x_q  <= div_sat;
            div_num_q <= DIV_N'(sh_c) << FRAC_BITS;
            div_rem_q <= '0;
            div_cnt_q <= CNT_W'(DIV_N - 1);
            state_q   <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          div_num_q <= div_quot;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            step_y_q <= div_sat;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Load address: position modulo the store dimension by repeated subtraction
  logic [LM_W-1:0]  lcol_m, lrow_m;
  logic [DIM_W-1:0] lcol, lrow;

  always_comb begin
    lcol_m = LM_W'(load_col_i);
    lrow_m = LM_W'(load_row_i);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (lcol_m >= LM_W'(MAX_SPRITE_DIM)) lcol_m = lcol_m - LM_W'(MAX_SPRITE_DIM);
      if (lrow_m >= LM_W'(MAX_SPRITE_DIM)) lrow_m = lrow_m - LM_W'(MAX_SPRITE_DIM);
    end
    lcol = DIM_W'(lcol_m);
    lrow = DIM_W'(lrow_m);
  end

  // Sample address: accumulator integer parts clamped to the last column and row
  logic [DIM_W-1:0]      sx, sy, sx_c, sy_c;
  logic [SRC_SIZE_W-1:0] sw_m1, sh_m1;

  always_comb begin
    sx    = acc_x_q[ACC_W-1:FRAC_BITS];
    sy    = acc_y_q[ACC_W-1:FRAC_BITS];
    sw_m1 = sw_c - 1'b1;
    sh_m1 = sh_c - 1'b1;
    sx_c  = (SZ_CMP_W'(sx) > SZ_CMP_W'(sw_m1)) ? DIM_W'(sw_m1) : sx;
    sy_c  = (SZ_CMP_W'(sy) > SZ_CMP_W'(sh_m1)) ? DIM_W'(sh_m1) : sy;
  end

  // Sprite store, registered read
  always_ff @(posedge clk_i) begin
    if (is_load) sprite_mem[{lrow, lcol}] <= load_color_i;
    if (is_step && active_q) rd_q <= sprite_mem[{sy_c, sx_c}];
  end

  // ---------------------------------------------------------------------------
  // Screen position and visibility
  logic [SCREEN_POS_W-1:0] scol, srow;
  logic                    on_screen;

  always_comb begin
    scol = {cfg_q.dest_left[DEST_W-1], cfg_q.dest_left} + SCREEN_POS_W'(col_cnt_q);
    srow = {cfg_q.dest_top[DEST_W-1], cfg_q.dest_top} + SCREEN_POS_W'(row_cnt_q);
    on_screen = ~scol[SCREEN_POS_W-1] & (SCR_CMP_W'(scol) < SCR_CMP_W'(SCREEN_W)) &
                ~srow[SCREEN_POS_W-1] & (SCR_CMP_W'(srow) < SCR_CMP_W'(SCREEN_H));
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (is_step) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_step) begin
      pv_q    <= active_q;
      onscr_q <= active_q & on_screen;
      col_q   <= active_q ? scol : '0;
      row_q   <= active_q ? srow : '0;
      last_q  <= active_q & end_col & end_row;
    end
  end

  assign out_valid_o    = ov_q;
  assign pixel_valid_o  = pv_q;
  assign color_o        = pv_q ? rd_q : '0;
  assign write_enable_o = pv_q & onscr_q & (rd_q != TRANSPARENT_KEY);
  assign screen_col_o   = col_q;
  assign screen_row_o   = row_q;
  assign last_pixel_o   = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_start_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> state_q == ST_DIV_X)
    else $error("start transfer did not launch the divider");

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_valid_o && !active_q)
    else $error("last pixel shown without closing the blit");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> step_x_q <= ACC_MAX && step_y_q <= ACC_MAX)
    else $error("source step above saturation limit");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_x_q <= ACC_MAX && acc_y_q <= ACC_MAX)
    else $error("source accumulator above saturation limit");

endmodule

@@ tb/tb_scaled_sprite_blitter_top.sv @@
// Self-checking testbench for scaled_sprite_blitter_top: a directed script, then random blits.
// A nearest-neighbour predictor inside the bench checks every pixel transfer.
// Depends on ssb_pkg and scaled_sprite_blitter_top.
`timescale 1ns / 100ps

module tb_scaled_sprite_blitter_top;
  import ssb_pkg::*;

  localparam int MAX_DIM       = 64;
  localparam int SCR_W         = 1024;
  localparam int SCR_H         = 768;
  localparam int FRAC          = 16;
  localparam int ACC_LIMIT     = (MAX_DIM << FRAC) - 1;
  localparam int ITEM_TARGET   = 950;
  localparam int TAIL_START    = 850;
  localparam int SETTLE_CYCLES = 64;   // lets the divider finish after a start
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SCRIPT_LEN    = 38;

  // action code the block drops without a result
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic                    pix_valid;
    logic                    wr_en;
    logic [SCREEN_POS_W-1:0] col;
    logic [SCREEN_POS_W-1:0] row;
    logic [COLOR_W-1:0]      color;
    logic                    last;
  } pixel_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  idx;
    logic [PDATA_W-1:0]    value;
    logic [ACTION_W-1:0]   act;
    logic [LOAD_POS_W-1:0] lc;
    logic [LOAD_POS_W-1:0] lr;
    logic [COLOR_W-1:0]    color;
    bit                    typed;
    pixel_t                want;
  } row_t;

  // DUT signals
  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_stall_o;
  logic [ACTION_W-1:0] action_i;
  logic [LOAD_POS_W-1:0] load_col_i, load_row_i;
  logic [COLOR_W-1:0] load_color_i;
  logic out_valid_o, out_stall_i;
  logic pixel_valid_o, write_enable_o, last_pixel_o;
  logic signed [SCREEN_POS_W-1:0] screen_col_o, screen_row_o;
  logic [COLOR_W-1:0] color_o;

  // Predictor state
  logic [COLOR_W-1:0] sprite_mem [0:MAX_DIM*MAX_DIM-1];
  bit                 loaded     [0:MAX_DIM*MAX_DIM-1];
  logic [21:0]        stp_x, stp_y, acc_x, acc_y;
  logic [COUNT_W-1:0] col_cnt, row_cnt;
  bit                 blit_on;
  cfg_regs_t          shadow;

  pixel_t expected_pixels [$];
  row_t   script [SCRIPT_LEN];
  int     errors, items_done, pixels_checked, blits_started, reg_writes;
  int     cycle_cnt, stall_left;
  bit     idle_en;

  scaled_sprite_blitter_top dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .action_i, .load_col_i, .load_row_i, .load_color_i,
    .out_valid_o, .out_stall_i, .pixel_valid_o, .write_enable_o,
    .screen_col_o, .screen_row_o, .color_o, .last_pixel_o
  );

  // Clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int dim(logic [11:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [21:0] step_of(int src, int dst);
    longint q;
    if (src == dst) return 22'(1 << FRAC);
    q = (longint'(src) << FRAC) / dst;
    if (q > ACC_LIMIT) q = ACC_LIMIT;
    return 22'(q);
  endfunction

  function automatic logic [21:0] add_sat(logic [21:0] a, logic [21:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > ACC_LIMIT) ? 22'(ACC_LIMIT) : 22'(s);
  endfunction

  // store index the next pixel transfer will sample, -1 when no blit runs
  function automatic int read_addr();
    int sx, sy, sw, sh;
    if (!blit_on) return -1;
    sw = dim(DEST_W'(shadow.src_width), MAX_DIM);
    sh = dim(DEST_W'(shadow.src_height), MAX_DIM);
    sx = int'(acc_x >> FRAC);
    sy = int'(acc_y >> FRAC);
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    return sy * MAX_DIM + sx;
  endfunction

  // advance the blitter by one accepted item; has_res tells whether it emits a pixel
  function automatic void advance_blitter(logic [ACTION_W-1:0] act, logic [5:0] lc,
                                          logic [5:0] lr, logic [COLOR_W-1:0] din,
                                          output bit has_res, output pixel_t res);
    int sw, sh, dw, dh, addr, left, top, col, row;
    bit on_scr, end_c, end_r;
    logic [COLOR_W-1:0] c;
    has_res = 1'b0;
    res     = '0;
    sw = dim(DEST_W'(shadow.src_width), MAX_DIM);
    sh = dim(DEST_W'(shadow.src_height), MAX_DIM);
    dw = dim(shadow.dest_width, int'(DEST_MAX));
    dh = dim(shadow.dest_height, int'(DEST_MAX));
    case (act)
      ACT_LOAD: begin
        sprite_mem[{lr, lc}] = din;
        loaded[{lr, lc}]     = 1'b1;
      end
      ACT_START: begin
        stp_x   = step_of(sw, dw);
        stp_y   = step_of(sh, dh);
        acc_x   = '0;
        acc_y   = '0;
        col_cnt = '0;
        row_cnt = '0;
        blit_on = 1'b1;
      end
      ACT_STEP: begin
        has_res = 1'b1;
        if (blit_on) begin
          addr   = read_addr();
          c      = sprite_mem[addr];
          left   = int'({{20{shadow.dest_left[11]}}, shadow.dest_left});
          top    = int'({{20{shadow.dest_top[11]}}, shadow.dest_top});
          col    = left + int'(col_cnt);
          row    = top + int'(row_cnt);
          on_scr = (col >= 0) && (col < SCR_W) && (row >= 0) && (row < SCR_H);
          end_c  = int'(col_cnt) >= dw - 1;
          end_r  = int'(row_cnt) >= dh - 1;
          res = pixel_t'{1'b1, (c != TRANSPARENT_KEY) && on_scr, col[12:0], row[12:0],
                         c, end_c && end_r};
          // raster walk: column first, then row, end of rectangle stops the blit
          if (end_c) begin
            col_cnt = '0;
            acc_x   = '0;
            if (end_r) begin
              blit_on = 1'b0;
              row_cnt = '0;
              acc_y   = '0;
            end else begin
              row_cnt = row_cnt + 1'b1;
              acc_y   = add_sat(acc_y, stp_y);
            end
          end else begin
            col_cnt = col_cnt + 1'b1;
            acc_x   = add_sat(acc_x, stp_x);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic [COLOR_W-1:0] rand_color();
    return ($urandom_range(0, 3) == 0) ? TRANSPARENT_KEY : COLOR_W'($urandom());
  endfunction

  // one item transfer on the input channel, with an optional gap ahead of it
  task automatic send_item(logic [ACTION_W-1:0] act, logic [5:0] lc, logic [5:0] lr,
                           logic [COLOR_W-1:0] din, bit typed, pixel_t want);
    bit has_res;
    pixel_t res;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    action_i     = act;
    load_col_i   = lc;
    load_row_i   = lr;
    load_color_i = din;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_blitter(act, lc, lr, din, has_res, res);
    if (has_res) expected_pixels.push_back(typed ? want : res);
    if (act != ACT_IGNORED) items_done++;
    if (act == ACT_START) blits_started++;
  endtask

  // pixel step; loads the sampled entry first if it was never written
  task automatic do_step(bit typed, pixel_t want);
    int addr;
    addr = read_addr();
    if (addr >= 0 && !loaded[addr])
      send_item(ACT_LOAD, addr[5:0], addr[11:6], rand_color(), 1'b0, '0);
    send_item(ACT_STEP, 6'($urandom()), 6'($urandom()), COLOR_W'($urandom()), typed, want);
  endtask

  // sender holds off until every pixel is back, then lets the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:   shadow.src_width   = val[SRC_SIZE_W-1:0];
      REG_SRC_HEIGHT:  shadow.src_height  = val[SRC_SIZE_W-1:0];
      REG_DEST_LEFT:   shadow.dest_left   = val[DEST_W-1:0];
      REG_DEST_TOP:    shadow.dest_top    = val[DEST_W-1:0];
      REG_DEST_WIDTH:  shadow.dest_width  = val[DEST_W-1:0];
      REG_DEST_HEIGHT: shadow.dest_height = val[DEST_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // register values: mostly small sizes, some extremes, out-of-range and edge positions
  function automatic logic [PDATA_W-1:0] rand_reg_value(logic [REG_IDX_W-1:0] idx);
    int pick;
    logic [PDATA_W-1:0] v;
    pick = $urandom_range(0, 9);
    case (idx) inside
      REG_SRC_WIDTH, REG_SRC_HEIGHT:
        v = (pick < 6) ? $urandom_range(1, 8) : (pick == 6) ? 64 :
            (pick == 7) ? $urandom_range(1, 64) : (pick == 8) ? 0 : $urandom_range(65, 127);
      REG_DEST_WIDTH, REG_DEST_HEIGHT:
        v = (pick < 6) ? $urandom_range(1, 10) : (pick == 6) ? 2048 :
            (pick == 7) ? $urandom_range(1, 2048) : (pick == 8) ? 0 :
            $urandom_range(2049, 4095);
      default: begin
        if (pick < 4) v = $urandom_range(0, 40);
        else if (pick == 4) v = ((idx == REG_DEST_LEFT) ? SCR_W : SCR_H) - $urandom_range(1, 12);
        else if (pick == 5) v = 32'(12'(-int'($urandom_range(1, 12))));
        else if (pick == 6) v = $urandom_range(0, 1) ? 2047 : 2048;
        else v = $urandom_range(0, 4095);
      end
    endcase
    // junk in bits above the register now and then
    if ($urandom_range(0, 7) == 0) v[31:12] = 20'($urandom());
    return v;
  endfunction

  // one random phase: reprogram while idle, usually start a blit, then walk it
  task automatic run_phase();
    int n_steps, remaining, sw, sh, dw, dh;
    logic [REG_IDX_W-1:0] idx;
    wait_idle();
    idle_en = (items_done < TAIL_START) && ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 3)) begin
      idx = REG_IDX_W'($urandom_range(0, 5));
      write_reg(idx, rand_reg_value(idx));
    end
    sw = dim(DEST_W'(shadow.src_width), MAX_DIM);
    sh = dim(DEST_W'(shadow.src_height), MAX_DIM);
    dw = dim(shadow.dest_width, int'(DEST_MAX));
    dh = dim(shadow.dest_height, int'(DEST_MAX));
    if ($urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(0, 6))
        send_item(ACT_LOAD, 6'($urandom_range(0, sw - 1)), 6'($urandom_range(0, sh - 1)),
                  rand_color(), 1'b0, '0);
      send_item(ACT_START, 6'($urandom()), 6'($urandom()), COLOR_W'($urandom()), 1'b0, '0);
    end
    remaining = (dh - 1 - int'(row_cnt)) * dw + (dw - int'(col_cnt));
    if (remaining <= 0) remaining = 1;
    if (remaining <= 160 && $urandom_range(0, 3) != 0)
      n_steps = remaining + $urandom_range(0, 2);
    else
      n_steps = $urandom_range(10, 60);
    repeat (n_steps) begin
      // noise between steps: stray loads, dropped codes, restarts
      case ($urandom_range(0, 39)) inside
        0, 1, 2: send_item(ACT_LOAD, 6'($urandom()), 6'($urandom()), rand_color(), 1'b0, '0);
        3:       send_item(ACT_IGNORED, 6'($urandom()), 6'($urandom()), COLOR_W'($urandom()),
                           1'b0, '0);
        4:       send_item(ACT_START, 6'($urandom()), 6'($urandom()), COLOR_W'($urandom()),
                           1'b0, '0);
        default: ;
      endcase
      do_step(1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- script rows

  function automatic row_t script_item(logic [ACTION_W-1:0] act, int lc, int lr,
                                       logic [COLOR_W-1:0] color);
    row_t r;
    r       = '{kind: ROW_ITEM, default: '0};
    r.act   = act;
    r.lc    = 6'(lc);
    r.lr    = 6'(lr);
    r.color = color;
    return r;
  endfunction

  function automatic row_t script_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
    row_t r;
    r       = '{kind: ROW_REG, default: '0};
    r.idx   = idx;
    r.value = val;
    return r;
  endfunction

  function automatic row_t script_check(pixel_t want);
    row_t r;
    r       = '{kind: ROW_ITEM, default: '0};
    r.act   = ACT_STEP;
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // ---------------------------------------------------------------- output side

  // random stall bursts on the pixel channel
  always @(negedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (idle_en && rst_ni && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
    out_stall_i = (stall_left != 0);
  end

  function automatic int field_differs(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v === got_v) return 0;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    return 1;
  endfunction

  // compare each pixel transfer with the oldest expectation
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: pixel transfer with nothing expected", $time);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        errors += field_differs("pixel_valid", 32'(want.pix_valid), 32'(pixel_valid_o));
        errors += field_differs("write_enable", 32'(want.wr_en), 32'(write_enable_o));
        errors += field_differs("screen_col", 32'(want.col), 32'(unsigned'(screen_col_o)));
        errors += field_differs("screen_row", 32'(want.row), 32'(unsigned'(screen_row_o)));
        errors += field_differs("color", want.color, color_o);
        errors += field_differs("last_pixel", 32'(want.last), 32'(last_pixel_o));
        pixels_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt,
               expected_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    action_i     = ACT_LOAD;
    load_col_i   = '0;
    load_row_i   = '0;
    load_color_i = '0;
    out_stall_i  = 1'b0;
    stall_left   = 0;
    idle_en      = 1'b1;
    errors       = 0;
    items_done   = 0;
    cycle_cnt    = 0;

    // predictor reset state
    foreach (loaded[i]) loaded[i] = 1'b0;
    stp_x   = '0;
    stp_y   = '0;
    acc_x   = '0;
    acc_y   = '0;
    col_cnt = '0;
    row_cnt = '0;
    blit_on = 1'b0;
    shadow  = '{src_width: 64, src_height: 64, dest_left: 0, dest_top: 0,
                dest_width: 64, dest_height: 64};

    // directed script: idle step, saturated step for a one-pixel target, off-screen key,
    // clamped sizes, load during a blit, shrink during a blit, restart, equal sizes
    script = '{
      script_check('0),
      script_item(ACT_IGNORED, 63, 63, 32'hFFFF_FFFF),
      script_item(ACT_LOAD, 0, 0, 32'h0000_0000),
      script_item(ACT_LOAD, 63, 63, 32'hFFFF_FFFF),
      script_reg(REG_DEST_WIDTH, 32'd1),
      script_reg(REG_DEST_HEIGHT, 32'd1),
      script_item(ACT_START, 0, 0, 32'h0),
      script_check(pixel_t'{1'b1, 1'b1, 13'd0, 13'd0, 32'd0, 1'b1}),
      script_check('0),
      script_reg(REG_DEST_LEFT, 32'h7FF),
      script_reg(REG_DEST_TOP, 32'h7FF),
      script_item(ACT_LOAD, 0, 0, 32'hFFFF_FFFF),
      script_item(ACT_START, 63, 63, 32'hFFFF_FFFF),
      script_check(pixel_t'{1'b1, 1'b0, 13'd2047, 13'd2047, 32'hFFFF_FFFF, 1'b1}),
      script_reg(REG_SRC_WIDTH, 32'd0),
      script_reg(REG_SRC_HEIGHT, 32'd127),
      script_reg(REG_DEST_LEFT, 32'h800),
      script_reg(REG_DEST_TOP, 32'h800),
      script_reg(REG_DEST_WIDTH, 32'hFFF),
      script_reg(REG_DEST_HEIGHT, 32'd0),
      script_item(ACT_START, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_LOAD, 0, 0, 32'h5A5A_00C3),
      script_item(ACT_STEP, 63, 63, 32'hFFFF_FFFF),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_reg(REG_SRC_WIDTH, 32'd2),
      script_reg(REG_SRC_HEIGHT, 32'd2),
      script_reg(REG_DEST_LEFT, 32'd0),
      script_reg(REG_DEST_TOP, 32'd0),
      script_reg(REG_DEST_WIDTH, 32'd2),
      script_reg(REG_DEST_HEIGHT, 32'd2),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_START, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0),
      script_item(ACT_STEP, 0, 0, 32'h0)
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].idx, script[i].value);
      end else if (script[i].act == ACT_STEP) begin
        do_step(script[i].typed, script[i].want);
      end else begin
        send_item(script[i].act, script[i].lc, script[i].lr, script[i].color, 1'b0, '0);
      end
    end

    // random blits; the tail of the run has no idling
    while (items_done < ITEM_TARGET) run_phase();
    idle_en = 1'b0;
    wait_idle();

    $display("Covered %0d items in %0d blits with %0d register writes.", items_done,
             blits_started, reg_writes);
    $display("%0d pixel transfers compared, %0d field errors.", pixels_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
